// ===== sv/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the console line editor
// Widths, character codes, result kinds and the command word that travels
// from the classifying front end to the executing back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  localparam int LINE_LEN = 32;
  localparam int ADDR_W   = $clog2(LINE_LEN);
  localparam int CNT_W    = $clog2(LINE_LEN + 1);
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 1'b1;
  localparam logic [BYTE_W-1:0]    OUT_LIMIT_RESET = 8'd32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    CMD_PRINT,
    CMD_ERASE,
    CMD_ENDL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [BYTE_W-1:0] ch;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/cle_if.sv =====
// ----------------------------------------------------------------------------
// cle_if: word channels of the console line editor
// The received-character channel and the result channel, each with
// valid/ready handshake and a source and a sink view.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_rx_if;
  import cle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_res_if;
  import cle_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

`default_nettype wire

// ===== sv/console_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// console_line_editor_unit: terminal line editor with echo
// Collects received characters into a line, handles erase and line end,
// echoes as configured and hands the completed line out word by word.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Payload
//   rx       in         valid/ready    rx_byte
//   res      out        valid/ready    out_kind, out_byte, out_last
//   cfg      in         cfg_we         cfg_index, cfg_data
//
// The classifier takes a received word in any cycle in which the two-entry
// command queue has room; ignored bytes are taken and dropped there.
// The executor takes a command from the queue only while it is idle and then
// produces any echo words for it; for a line end it then reads each line byte
// through the line store read port before loading it into the output register,
// and closes the line with the end marker.
// Reset is synchronous and clears the queue, the fill count, the output
// register and sets the configuration to its reset values; the line store itself is never cleared.
// A stalled result channel holds the output register and, behind it, the
// executor; the queue lets the input side run on until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor_unit (
  input  logic                              clk,
  input  logic                              rst,
  cle_rx_if.sink                            rx,
  cle_res_if.source                         res,
  input  logic                              cfg_we,
  input  logic [cle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cle_pkg::*;

  // Configuration registers; the user must write them only while the editor is idle, the block does not enforce it.
  logic              echo_enable;
  logic [BYTE_W-1:0] out_limit;

  // Command path between the classifier and the executor.
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
      out_limit   <= OUT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECHO_ENABLE: echo_enable <= cfg_data[0];
        REG_OUT_LIMIT:   out_limit   <= cfg_data[BYTE_W-1:0];
        default:         echo_enable <= echo_enable;
      endcase
    end
  end

  // Front end: sorts each received word into a command.
  cle_front u_front (
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Short queue so that input and output can stall independently.
  cle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Back end: line store, fill count and result sequencing.
  cle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .echo_enable (echo_enable),
    .out_limit   (out_limit),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .res         (res)
  );

endmodule

`default_nettype wire

// ===== sv/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front: character classifier
// Takes received words, sorts them into printable, erase and line-end
// commands and pushes those into the command queue; other bytes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_front (
  cle_rx_if.sink             rx,
  output logic               push_valid,
  input  logic               push_ready,
  output cle_pkg::cmd_t      push_cmd
);
  import cle_pkg::*;

  logic is_endl;
  logic is_erase;
  logic is_print;

  assign is_endl  = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
  assign is_erase = (rx.rx_byte == CH_BS) || (rx.rx_byte == CH_DEL);
  assign is_print = (rx.rx_byte >= CH_SP) && (rx.rx_byte <= CH_TILDE);

  // A word is taken whenever the queue has room; ignored bytes simply vanish.
  assign rx.ready   = push_ready;
  assign push_valid = rx.valid && (is_endl || is_erase || is_print);

  always_comb begin
    push_cmd.ch = rx.rx_byte;
    priority if (is_endl) begin
      push_cmd.op = CMD_ENDL;
    end else if (is_erase) begin
      push_cmd.op = CMD_ERASE;
    end else begin
      push_cmd.op = CMD_PRINT;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cle_queue.sv =====
// ----------------------------------------------------------------------------
// cle_queue: command queue
// A short first-in first-out buffer between the classifier and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cle_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cle_pkg::cmd_t pop_cmd
);
  import cle_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (level != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (level != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   level <= level + (QPTR_W + 1)'(1);
        2'b01:   level <= level - (QPTR_W + 1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back: command executor
// Owns the line store and fill count, carries out queued commands and
// produces echo, line and end-marker words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          echo_enable,
  input  logic [cle_pkg::BYTE_W-1:0]    out_limit,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  cle_pkg::cmd_t                 pop_cmd,
  cle_res_if.source                     res
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_LINE_RD,
    S_LINE_WR,
    S_END
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  line_cnt;
  cmd_op_t           seq_op;
  logic [BYTE_W-1:0] seq_ch;
  logic [1:0]        pos;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic [BYTE_W-1:0] store [LINE_LEN];
  logic [BYTE_W-1:0] rd_data;

  logic              slot_free;
  logic              load;
  logic              take;
  logic              has_room;
  logic              store_we;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W-1:0] fill_ext;
  logic [BYTE_W-1:0] cnt_ext;
  logic [BYTE_W-1:0] echo_ch;
  logic              seq_done;

  assign res.valid    = out_valid;
  assign res.out_kind = out_kind;
  assign res.out_byte = out_byte;
  assign res.out_last = out_last;

  assign slot_free = !out_valid || res.ready;
  assign load      = slot_free &&
                     ((state == S_ECHO) || (state == S_LINE_WR) || (state == S_END));
  assign pop_ready = (state == S_IDLE);
  assign take      = pop_valid && pop_ready;
  assign has_room  = (fill < CNT_W'(LINE_LEN - 1));
  assign store_we  = take && (pop_cmd.op == CMD_PRINT) && has_room;

  // Line bytes emitted: fill count clipped to out_limit - 1 (zero limit acts as one).
  assign limit    = (out_limit == '0) ? '0 : out_limit - BYTE_W'(1);
  assign fill_ext = BYTE_W'(fill);
  assign cnt_ext  = (fill_ext < limit) ? fill_ext : limit;

  always_comb begin
    unique case (seq_op)
      CMD_PRINT: begin
        echo_ch  = seq_ch;
        seq_done = 1'b1;
      end
      CMD_ERASE: begin
        echo_ch  = (pos == 2'd1) ? CH_SP : CH_BS;
        seq_done = (pos == 2'd2);
      end
      CMD_ENDL: begin
        echo_ch  = (pos == 2'd0) ? CH_CR : CH_LF;
        seq_done = (pos == 2'd1);
      end
      default: begin
        echo_ch  = seq_ch;
        seq_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[fill[ADDR_W-1:0]] <= pop_cmd.ch;
    end
    rd_data <= store[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            seq_op <= pop_cmd.op;
            seq_ch <= pop_cmd.ch;
            pos    <= 2'd0;
            unique case (pop_cmd.op)
              CMD_PRINT: begin
                if (has_room) begin
                  fill <= fill + CNT_W'(1);
                  if (echo_enable) begin
                    state <= S_ECHO;
                  end
                end
              end
              CMD_ERASE: begin
                if (fill != '0) begin
                  fill <= fill - CNT_W'(1);
                  if (echo_enable) begin
                    state <= S_ECHO;
                  end
                end
              end
              CMD_ENDL: begin
                fill     <= '0;
                idx      <= '0;
                line_cnt <= cnt_ext[CNT_W-1:0];
                priority if (echo_enable) begin
                  state <= S_ECHO;
                end else if (cnt_ext != '0) begin
                  state <= S_LINE_RD;
                end else begin
                  state <= S_END;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ECHO: begin
          if (slot_free) begin
            out_kind  <= KIND_ECHO;
            out_byte  <= echo_ch;
            out_last  <= seq_done && (seq_op != CMD_ENDL);
            pos       <= pos + 2'd1;
            if (seq_done) begin
              priority if (seq_op != CMD_ENDL) begin
                state <= S_IDLE;
              end else if (line_cnt != '0) begin
                state <= S_LINE_RD;
              end else begin
                state <= S_END;
              end
            end
          end
        end
        S_LINE_RD: begin
          state <= S_LINE_WR;
        end
        S_LINE_WR: begin
          if (slot_free) begin
            out_kind  <= KIND_LINE;
            out_byte  <= rd_data;
            out_last  <= 1'b0;
            idx       <= idx + CNT_W'(1);
            state     <= ((idx + CNT_W'(1)) == line_cnt) ? S_END : S_LINE_RD;
          end
        end
        S_END: begin
          if (slot_free) begin
            out_kind  <= KIND_END;
            out_byte  <= CH_NUL;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker: port-level checks for the console line editor
// Watches the result channel of the top level and flags malformed results.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [cle_pkg::KIND_W-1:0]    res_kind,
  input logic [cle_pkg::BYTE_W-1:0]    res_byte,
  input logic                          res_last
);
  import cle_pkg::*;

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result word stays and keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_byte)
      && $stable(res_last))
    else $error("stalled result word changed");

  // The end marker carries a zero byte and always closes its sequence.
  a_end_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_END) |-> (res_byte == CH_NUL) && res_last)
    else $error("malformed end marker");

  // A line byte is always followed by more of the line or its end marker.
  a_line_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_LINE) |-> !res_last)
    else $error("line byte flagged as last");

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.out_kind),
  .res_byte  (res.out_byte),
  .res_last  (res.out_last)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the console line editor
// Sends received characters through the rx channel and predicts every echo,
// line and end-of-line word. Each word on the result channel is checked
// field by field against the oldest prediction. Random gaps are applied on
// both channels, and both configuration registers are swept through their
// extremes while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
  import cle_pkg::*;

  // Run length bounds. The cycle limit lies far above the slowest line end,
  // even when occasional stalls stretch it.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_WORDS  = 30;
  localparam int GAP_PERCENT   = 6;
  localparam int REPORT_CAP    = 30;

  // One predicted word on the result channel.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cle_rx_if  rx_ch ();
  cle_res_if res_ch ();

  console_line_editor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the editor: line contents, fill count and both registers.
  logic [BYTE_W-1:0] line_chars [LINE_LEN];
  int unsigned       line_fill;
  logic              echo_on;
  logic [BYTE_W-1:0] rx_buf_size;

  // Words still owed by the block, oldest first.
  result_word_t pending_words[$];

  // Bookkeeping for the summary and the verdict.
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned acted_words;
  int unsigned lines_ended;
  int unsigned results_checked;
  int unsigned cycle_count;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Every input starts at a known value, with reset asserted.
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_ECHO_ENABLE;
    cfg_data       = '0;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = CH_NUL;
    res_ch.ready   = 1'b0;
  end

  // The line store is left undefined by reset, but only entries that were
  // written are ever read out, so the shadow starts from zero.
  function automatic void reset_shadow();
    foreach (line_chars[i]) line_chars[i] = CH_NUL;
    line_fill   = 0;
    echo_on     = 1'b1;
    rx_buf_size = OUT_LIMIT_RESET;
  endfunction

  // Works out the words caused by one accepted character and queues them.
  function automatic void predict_editor(logic [BYTE_W-1:0] ch);
    result_word_t batch[$];
    int unsigned  emit_max;
    int unsigned  emit_count;
    batch = {};
    if (ch == CH_CR || ch == CH_LF) begin
      // A buffer size of zero behaves like one: no line bytes at all.
      emit_max   = (rx_buf_size == 0) ? 0 : rx_buf_size - 1;
      emit_count = (line_fill < emit_max) ? line_fill : emit_max;
      if (echo_on) begin
        batch.push_back('{KIND_ECHO, CH_CR, 1'b0});
        batch.push_back('{KIND_ECHO, CH_LF, 1'b0});
      end
      for (int unsigned i = 0; i < emit_count && i < LINE_LEN; i++)
        batch.push_back('{KIND_LINE, line_chars[i], 1'b0});
      batch.push_back('{KIND_END, CH_NUL, 1'b0});
      line_fill = 0;
      acted_words++;
      lines_ended++;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      // Erasing an empty line is silently ignored.
      if (line_fill > 0) begin
        line_fill--;
        if (echo_on) begin
          batch.push_back('{KIND_ECHO, CH_BS, 1'b0});
          batch.push_back('{KIND_ECHO, CH_SP, 1'b0});
          batch.push_back('{KIND_ECHO, CH_BS, 1'b0});
        end
      end
      acted_words++;
    end else if (ch >= CH_SP && ch <= CH_TILDE) begin
      // One slot is kept back, so a full line drops the character unechoed.
      if (line_fill < LINE_LEN - 1) begin
        line_chars[line_fill] = ch;
        line_fill++;
        if (echo_on) batch.push_back('{KIND_ECHO, ch, 1'b0});
      end
      acted_words++;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_words.push_back(batch[i]);
  endfunction

  // Result side: ready drops at random, GAP_PERCENT percent of the time, unless gaps are
  // switched off for the current stretch of the run.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Every accepted result word is compared with the oldest prediction.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_checked++;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: result word with nothing expected: kind %0d byte %h last %b",
                   $time, res_ch.out_kind, res_ch.out_byte, res_ch.out_last);
      end else begin
        want = pending_words.pop_front();
        if (res_ch.out_kind !== want.kind || res_ch.out_byte !== want.data ||
            res_ch.out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP) begin
            if (res_ch.out_kind !== want.kind)
              $display("%0t: out_kind expected %0d actual %0d",
                       $time, want.kind, res_ch.out_kind);
            if (res_ch.out_byte !== want.data)
              $display("%0t: out_byte expected %h actual %h",
                       $time, want.data, res_ch.out_byte);
            if (res_ch.out_last !== want.last)
              $display("%0t: out_last expected %b actual %b",
                       $time, want.last, res_ch.out_last);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped by the cycle limit, %0d words still owed",
               $time, pending_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one character and returns at the falling edge after it has been
  // taken. Valid is only lowered during a gap, never in the step where it is
  // raised again for the next word.
  task automatic send_char(input logic [BYTE_W-1:0] ch);
    while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= ch;
    do @(posedge clk); while (!rx_ch.ready);
    words_sent++;
    predict_editor(ch);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Holds the sender back until every owed word has arrived, then lets the
  // executor finish any character that produces nothing.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes only happen with the block idle; the shadow follows the
  // write at the edge where it takes effect.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == REG_ECHO_ENABLE) echo_on = value[0];
    else rx_buf_size = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Reset values: echo on, a 32-byte buffer, both ends of the printable range.
  task automatic test_default_line();
    send_char(8'h41);
    send_char(CH_SP);
    send_char(CH_TILDE);
    send_char(CH_CR);
  endtask

  // Erasing an empty line does nothing; erase after text echoes BS SP BS.
  task automatic test_erase();
    send_char(CH_BS);
    send_char(CH_DEL);
    send_text("xy");
    send_char(CH_BS);
    send_char(8'h7A);
    send_char(CH_DEL);
    send_char(CH_LF);
  endtask

  // Control bytes other than CR, LF, BS and DEL, and the top half of the
  // byte range, are taken and dropped.
  task automatic test_ignored_bytes();
    send_char(CH_NUL);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h1F);
    send_char(8'h09);
    send_char(CH_CR);
  endtask

  // With echo off only the line bytes and the end marker come out.
  task automatic test_echo_off();
    write_reg(REG_ECHO_ENABLE, 8'h00);
    send_text("qr");
    send_char(CH_BS);
    send_char(CH_CR);
    write_reg(REG_ECHO_ENABLE, 8'h01);
  endtask

  // Truncation of the emitted line at buffer size minus one, including the
  // smallest sizes, where nothing but the end marker is left.
  task automatic test_buffer_size();
    write_reg(REG_OUT_LIMIT, 8'd3);
    send_text("abcde");
    send_char(CH_CR);
    write_reg(REG_OUT_LIMIT, 8'd1);
    send_text("fg");
    send_char(CH_LF);
    write_reg(REG_OUT_LIMIT, 8'd0);
    send_char(8'h68);
    send_char(CH_CR);
    write_reg(REG_OUT_LIMIT, 8'd255);
    send_char(8'h69);
    send_char(CH_CR);
  endtask

  // Overfilling the line: the surplus is dropped without echo and the whole
  // stored line comes out. Run with no gaps at all on either side.
  task automatic test_line_full();
    no_gaps = 1'b1;
    for (int i = 0; i < LINE_LEN + 2; i++) send_char(8'(8'h30 + i));
    send_char(CH_DEL);
    send_char(8'h21);
    send_char(8'h22);
    send_char(CH_CR);
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // Random lines of printable text with erases and noise mixed in, under a
  // new register setting every few lines. One phase runs without gaps.
  task automatic test_random_lines();
    int unsigned first_acted;
    int unsigned line_no;
    int unsigned phase_no;
    int unsigned line_words;
    int unsigned pick;
    logic [BYTE_W-1:0] ch;
    first_acted = acted_words;
    line_no     = 0;
    phase_no    = 0;
    while (acted_words - first_acted < RANDOM_WORDS) begin
      if (line_no % 3 == 0) begin
        write_reg(REG_ECHO_ENABLE, 8'($urandom_range(1)));
        pick = $urandom_range(9);
        if (pick == 0)      write_reg(REG_OUT_LIMIT, 8'd1);
        else if (pick == 1) write_reg(REG_OUT_LIMIT, 8'd255);
        else                write_reg(REG_OUT_LIMIT, 8'($urandom_range(2, 40)));
        no_gaps = (phase_no == 1);
        phase_no++;
      end
      // Mostly short lines, now and then one long enough to fill up.
      line_words = ($urandom_range(7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 9);
      repeat (line_words) begin
        pick = $urandom_range(99);
        if (pick < 10)      ch = $urandom_range(1) ? CH_BS : CH_DEL;
        else if (pick < 17) ch = 8'($urandom_range(255));
        else                ch = 8'($urandom_range(CH_SP, CH_TILDE));
        send_char(ch);
      end
      send_char($urandom_range(1) ? CH_CR : CH_LF);
      line_no++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    mismatch_count  = 0;
    words_sent      = 0;
    acted_words     = 0;
    lines_ended     = 0;
    results_checked = 0;
    cycle_count     = 0;
    no_gaps         = 1'b0;
    reset_shadow();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    test_default_line();
    test_erase();
    test_ignored_bytes();
    test_echo_off();
    test_buffer_size();
    test_line_full();
    test_random_lines();

    wait_idle();
    $display("Sent %0d characters, %0d lines ended; checked %0d result words.",
             words_sent, lines_ended, results_checked);
    $display("Covered echo on and off, buffer sizes 0, 1, 3, 255 and random, full lines.");
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
